### src/rbce_pkg.sv
// ----------------------------------------------------------------------------
// rbce_pkg: run-length blitter command engine package
// beat types, command and result codes, configuration bundle and plane mask
// ----------------------------------------------------------------------------
package rbce_pkg;

  // rom address width of the source pointer
  localparam int unsigned SrcAddrBits = 22;
  localparam logic [21:0] SrcAddrMask = 22'((64'd1 << SrcAddrBits) - 64'd1);

  // queue depths (two entries, one-bit pointers)
  localparam int unsigned QueueDepth = 2;

  // input func codes
  localparam logic [1:0] FuncStart   = 2'd0;
  localparam logic [1:0] FuncDeliver = 2'd1;
  localparam logic [1:0] FuncAdvance = 2'd2;

  // plane layouts
  localparam logic [1:0] LayoutFour     = 2'd0;
  localparam logic [1:0] LayoutFourDual = 2'd1;
  localparam logic [1:0] LayoutThreePair = 2'd2;

  // configuration register indexes
  localparam logic [2:0] RegLayoutMode  = 3'd0;
  localparam logic [2:0] RegDestLayers  = 3'd1;
  localparam logic [2:0] RegPenRegister = 3'd2;
  localparam logic [2:0] RegActiveHalf  = 3'd3;
  localparam logic [2:0] RegBothHalves  = 3'd4;
  localparam logic [2:0] RegFlipScreen  = 3'd5;
  localparam logic [2:0] RegIrqEnable   = 3'd6;
  localparam logic [2:0] RegRomLength   = 3'd7;

  // command stream opcodes (low nibble)
  localparam logic [3:0] OpStop    = 4'd0;
  localparam logic [3:0] OpCount   = 4'd12;
  localparam logic [3:0] OpSkipA   = 4'd13;
  localparam logic [3:0] OpSkipB   = 4'd14;
  localparam logic [3:0] OpNextRow = 4'd15;

  // blit flag bits
  localparam int unsigned FlagFill     = 0;
  localparam int unsigned FlagOverride = 1;
  localparam int unsigned FlagSwap     = 3;

  // dest_layers bit that widens the pen
  localparam int unsigned LayerPenOr = 4;

  typedef enum logic [1:0] {
    OpStart   = 2'd0,
    OpDeliver = 2'd1,
    OpAdvance = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KindFetch = 2'd0,
    KindPixel = 2'd1,
    KindFill  = 2'd2,
    KindDone  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [21:0] src_address;
    logic [15:0] dest_xy;
    logic [7:0]  blit_flags;
    logic [7:0]  rom_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [21:0] address;
    logic [7:0]  pen;
    logic [7:0]  plane_mask;
    logic [16:0] fill_length;
    logic        overrun;
    logic        irq;
  } out_item_t;

  // classified command travelling from front to back
  typedef struct packed {
    op_e         op;
    logic [21:0] src_address;
    logic [15:0] dest_xy;
    logic [7:0]  blit_flags;
    logic [7:0]  rom_byte;
  } cmd_t;

  // queue handshake between front and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_q_t;

  typedef struct packed {
    logic [1:0]  layout_mode;
    logic [7:0]  dest_layers;
    logic [7:0]  pen_register;
    logic        active_half;
    logic        both_halves;
    logic        flip_screen;
    logic        irq_enable;
    logic [22:0] rom_length;
  } cfg_t;

  function automatic logic [7:0] half_mask(logic [7:0] layers, logic half, logic both);
    logic [7:0] m;
    m = '0;
    for (int l = 0; l < 4; l++) begin
      if (layers[l]) begin
        m[l*2 + int'(half)] = 1'b1;
        if (both) begin
          m[l*2 + 1 - int'(half)] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  function automatic logic [7:0] plane_mask_for(cfg_t cfg, logic fill);
    logic [7:0] m;
    case (cfg.layout_mode)
      LayoutFour:      m = half_mask(cfg.dest_layers, cfg.active_half, fill);
      LayoutFourDual:  m = half_mask(cfg.dest_layers, cfg.active_half, cfg.both_halves);
      LayoutThreePair: m = {2'b00, cfg.dest_layers[5:0]};
      default:         m = {5'b00000, cfg.dest_layers[1], 1'b0, cfg.dest_layers[0]};
    endcase
    return m;
  endfunction

endpackage

### src/rbce_front.sv
// ----------------------------------------------------------------------------
// rbce_front: command front end
// classifies input beats and holds them in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module rbce_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rbce_pkg::in_item_t  in_data_i,
  output rbce_pkg::cmd_q_t    cmd_q_o,
  input  logic                cmd_pop_i
);

  logic [1:0]     cnt_q, cnt_d;
  logic           wr_q, rd_q;
  rbce_pkg::cmd_t buf_q [rbce_pkg::QueueDepth];
  rbce_pkg::cmd_t cls;
  logic           known;
  logic           accept, push;

  // func 3 means nothing and is dropped here
  always_comb begin
    cls             = '0;
    cls.src_address = in_data_i.src_address;
    cls.dest_xy     = in_data_i.dest_xy;
    cls.blit_flags  = in_data_i.blit_flags;
    cls.rom_byte    = in_data_i.rom_byte;
    known           = 1'b1;
    case (in_data_i.func)
      rbce_pkg::FuncStart:   cls.op = rbce_pkg::OpStart;
      rbce_pkg::FuncDeliver: cls.op = rbce_pkg::OpDeliver;
      rbce_pkg::FuncAdvance: cls.op = rbce_pkg::OpAdvance;
      default: begin
        cls.op = rbce_pkg::OpStart;
        known  = 1'b0;
      end
    endcase
  end

  assign in_stall_o = (cnt_q == 2'(rbce_pkg::QueueDepth));
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && known;

  assign cmd_q_o.valid = (cnt_q != 2'd0);
  assign cmd_q_o.cmd   = buf_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (cmd_pop_i) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= cls;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(rbce_pkg::QueueDepth))
    else $error("command queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cnt_q != 2'd0)
    else $error("pop from empty command queue");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(rbce_pkg::QueueDepth) && !cmd_pop_i) |=> in_stall_o)
    else $error("full queue not stalling input");
`endif

endmodule

### src/rbce_back.sv
// ----------------------------------------------------------------------------
// rbce_back: command back end
// walks the blit state one command per cycle while the result buffer has room, and buffers results
// ----------------------------------------------------------------------------
module rbce_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbce_pkg::cfg_t      cfg_i,
  input  rbce_pkg::cmd_q_t    cmd_q_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rbce_pkg::out_item_t out_data_o
);

  typedef enum logic [5:0] {
    PhIdle  = 6'b000001,
    PhCmd   = 6'b000010,
    PhSkip  = 6'b000100,
    PhCount = 6'b001000,
    PhDraw  = 6'b010000,
    PhNext  = 6'b100000
  } phase_e;

  phase_e      phase_q, phase_d, fetch_ph;
  logic [21:0] ptr_q, ptr_d;
  logic [7:0]  cx_q, cx_d, cy_q, cy_d, rsx_q, rsx_d;
  logic [3:0]  pen_q, pen_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  flags_q, flags_d;

  rbce_pkg::cmd_t      cmd;
  rbce_pkg::out_item_t res;
  logic                has_res, do_fetch;
  logic [7:0]          b, px, py;
  logic [7:0]          ppen;
  logic [21:0]         ptr_inc;

  logic [1:0]          ocnt_q;
  logic                owr_q, ord_q;
  rbce_pkg::out_item_t obuf_q [rbce_pkg::QueueDepth];
  logic                push, pop_out;

  assign cmd       = cmd_q_i.cmd;
  assign cmd_pop_o = cmd_q_i.valid && (ocnt_q != 2'(rbce_pkg::QueueDepth));
  assign b         = cmd.rom_byte;
  assign ptr_inc   = (ptr_q + 22'd1) & rbce_pkg::SrcAddrMask;

  // pixel coordinates and pen
  always_comb begin
    px = cx_q;
    py = cy_q;
    if (cfg_i.flip_screen) begin
      px = ~cx_q;
      py = ~cy_q;
    end
    if (flags_q[rbce_pkg::FlagSwap]) begin
      px = cfg_i.flip_screen ? ~cy_q : cy_q;
      py = cfg_i.flip_screen ? ~cx_q : cx_q;
    end
    ppen = {4'h0, pen_q};
    if (flags_q[rbce_pkg::FlagOverride]) begin
      ppen = {4'h0, cfg_i.pen_register[7:4]};
    end
    if (cfg_i.dest_layers[rbce_pkg::LayerPenOr]) begin
      ppen = ppen | {cfg_i.pen_register[6:0], 1'b0};
    end
  end

  always_comb begin
    phase_d  = phase_q;
    ptr_d    = ptr_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    rsx_d    = rsx_q;
    pen_d    = pen_q;
    left_d   = left_q;
    flags_d  = flags_q;
    res      = '0;
    has_res  = 1'b0;
    do_fetch = 1'b0;
    fetch_ph = PhCmd;
    if (cmd_pop_o) begin
      case (cmd.op)
        rbce_pkg::OpStart: begin
          flags_d = cmd.blit_flags;
          ptr_d   = cmd.src_address & rbce_pkg::SrcAddrMask;
          cx_d    = cmd.dest_xy[7:0];
          cy_d    = cmd.dest_xy[15:8];
          rsx_d   = cmd.dest_xy[7:0];
          left_d  = '0;
          pen_d   = '0;
          if (cmd.blit_flags[rbce_pkg::FlagFill]) begin
            has_res         = 1'b1;
            res.kind        = rbce_pkg::KindFill;
            res.address     = cfg_i.flip_screen ? 22'd0 : {6'd0, cmd.dest_xy};
            res.pen         = {4'h0, cfg_i.pen_register[7:4]};
            res.plane_mask  = rbce_pkg::plane_mask_for(cfg_i, 1'b1);
            res.fill_length = 17'h10000 - {1'b0, cmd.dest_xy};
            phase_d         = PhIdle;
          end else begin
            do_fetch = 1'b1;
            fetch_ph = PhCmd;
          end
        end
        rbce_pkg::OpDeliver: begin
          case (phase_q)
            PhCmd: begin
              ptr_d = ptr_inc;
              pen_d = b[7:4];
              case (b[3:0])
                rbce_pkg::OpStop: begin
                  has_res     = 1'b1;
                  res.kind    = rbce_pkg::KindDone;
                  res.address = ptr_inc;
                  res.irq     = cfg_i.irq_enable;
                  phase_d     = PhIdle;
                end
                rbce_pkg::OpNextRow: begin
                  cy_d     = flags_q[rbce_pkg::FlagSwap] ? cy_q - 8'd1 : cy_q + 8'd1;
                  cx_d     = rsx_q;
                  do_fetch = 1'b1;
                  fetch_ph = PhCmd;
                end
                rbce_pkg::OpSkipA, rbce_pkg::OpSkipB: begin
                  do_fetch = 1'b1;
                  fetch_ph = PhSkip;
                end
                rbce_pkg::OpCount: begin
                  do_fetch = 1'b1;
                  fetch_ph = PhCount;
                end
                default: begin
                  left_d  = {4'h0, b[3:0]};
                  phase_d = PhDraw;
                end
              endcase
            end
            PhSkip: begin
              ptr_d    = ptr_inc;
              cx_d     = rsx_q + b;
              do_fetch = 1'b1;
              fetch_ph = PhCount;
            end
            PhCount: begin
              ptr_d = ptr_inc;
              if (b == 8'd0) begin
                do_fetch = 1'b1;
                fetch_ph = PhCmd;
              end else begin
                left_d  = b;
                phase_d = PhDraw;
              end
            end
            default: begin
            end
          endcase
        end
        rbce_pkg::OpAdvance: begin
          case (phase_q)
            PhDraw: begin
              has_res        = 1'b1;
              res.kind       = rbce_pkg::KindPixel;
              res.address    = {6'd0, py, px};
              res.pen        = ppen;
              res.plane_mask = rbce_pkg::plane_mask_for(cfg_i, 1'b0);
              cx_d           = cx_q + 8'd1;
              left_d         = left_q - 8'd1;
              if (left_q == 8'd1) begin
                phase_d = PhNext;
              end
            end
            PhNext: begin
              do_fetch = 1'b1;
              fetch_ph = PhCmd;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
      // fetch request, or end of blit when the pointer runs off the rom
      if (do_fetch) begin
        has_res     = 1'b1;
        res.address = ptr_d;
        if ({1'b0, ptr_d} >= cfg_i.rom_length) begin
          res.kind    = rbce_pkg::KindDone;
          res.overrun = 1'b1;
          res.irq     = cfg_i.irq_enable;
          phase_d     = PhIdle;
        end else begin
          res.kind = rbce_pkg::KindFetch;
          phase_d  = fetch_ph;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      ptr_q   <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      rsx_q   <= '0;
      pen_q   <= '0;
      left_q  <= '0;
      flags_q <= '0;
    end else begin
      phase_q <= phase_d;
      ptr_q   <= ptr_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      rsx_q   <= rsx_d;
      pen_q   <= pen_d;
      left_q  <= left_d;
      flags_q <= flags_d;
    end
  end

  // result buffer
  assign push        = cmd_pop_o && has_res;
  assign out_valid_o = (ocnt_q != 2'd0);
  assign pop_out     = out_valid_o && !out_stall_i;
  assign out_data_o  = obuf_q[ord_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
    end else begin
      if (push && !pop_out) begin
        ocnt_q <= ocnt_q + 2'd1;
      end else if (!push && pop_out) begin
        ocnt_q <= ocnt_q - 2'd1;
      end
      if (push) begin
        owr_q <= ~owr_q;
      end
      if (pop_out) begin
        ord_q <= ~ord_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      obuf_q[owr_q] <= res;
    end
  end

`ifndef ASSERT_OFF
  a_obuf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= 2'(rbce_pkg::QueueDepth))
    else $error("result buffer count out of range");

  a_no_pop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q == 2'(rbce_pkg::QueueDepth) |-> !cmd_pop_o)
    else $error("command taken with full result buffer");

  a_fill_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd.op == rbce_pkg::OpStart && cmd.blit_flags[rbce_pkg::FlagFill])
    |=> phase_q == PhIdle)
    else $error("fill did not end the blit");

  a_draw_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDraw |-> left_q != 8'd0)
    else $error("drawing with empty run");
`endif

endmodule

### src/rle_blitter_command_engine_core.sv
// ----------------------------------------------------------------------------
// rle_blitter_command_engine_core: run-length blitter command engine
// decodes run-length drawing commands fed one rom byte per beat and issues
// fetch requests, pixel writes, fill orders and done reports
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  rbce_pkg::in_item_t
//   out      output     out_valid / stall    rbce_pkg::out_item_t
//   cfg      input      cfg_valid / ready    cfg_index (3b), cfg_data (23b)
//
// one beat per clock is taken on the input and one result per clock leaves
// the output while nothing stalls; a beat's result is held first in the front
// queue and then in the back end's result buffer; the back end updates the
// blit state once per cycle while the result buffer has room, setting that rate
// reset clears queues, blit state and config to defaults (irq_enable on,
// rom_length 4 MiB); output stalls fill the result buffer and then the
// command queue before the input stalls
//
module rle_blitter_command_engine_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input beats
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rbce_pkg::in_item_t  in_data_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rbce_pkg::out_item_t out_data_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [22:0]         cfg_data_i
);

  rbce_pkg::cfg_t   cfg_q;
  rbce_pkg::cmd_q_t cmd_q;
  logic             cmd_pop;

  // config writes land at once, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.layout_mode  <= '0;
      cfg_q.dest_layers  <= '0;
      cfg_q.pen_register <= '0;
      cfg_q.active_half  <= 1'b0;
      cfg_q.both_halves  <= 1'b0;
      cfg_q.flip_screen  <= 1'b0;
      cfg_q.irq_enable   <= 1'b1;
      cfg_q.rom_length   <= 23'h400000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rbce_pkg::RegLayoutMode:  cfg_q.layout_mode  <= cfg_data_i[1:0];
        rbce_pkg::RegDestLayers:  cfg_q.dest_layers  <= cfg_data_i[7:0];
        rbce_pkg::RegPenRegister: cfg_q.pen_register <= cfg_data_i[7:0];
        rbce_pkg::RegActiveHalf:  cfg_q.active_half  <= cfg_data_i[0];
        rbce_pkg::RegBothHalves:  cfg_q.both_halves  <= cfg_data_i[0];
        rbce_pkg::RegFlipScreen:  cfg_q.flip_screen  <= cfg_data_i[0];
        rbce_pkg::RegIrqEnable:   cfg_q.irq_enable   <= cfg_data_i[0];
        rbce_pkg::RegRomLength:   cfg_q.rom_length   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // front: classify beats, drop meaningless func codes, queue them
  rbce_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cmd_q_o    (cmd_q),
    .cmd_pop_i  (cmd_pop)
  );

  // back: blit state walk and result buffer
  rbce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_q_i     (cmd_q),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### dv/rle_blitter_command_engine_checker.sv
// ----------------------------------------------------------------------------
// rle_blitter_command_engine_checker: result checker for the blitter engine
// watches the input, result and configuration channels, predicts every
// result beat from its own copy of the blit state and compares in order
// ----------------------------------------------------------------------------
module rle_blitter_command_engine_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  rbce_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  rbce_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [22:0]         cfg_data_i,
  output int                  mismatches_o,
  output int                  outstanding_o
);
  import rbce_pkg::*;

  typedef enum logic [2:0] {
    BlitIdle, BlitCmd, BlitSkip, BlitCount, BlitDraw, BlitRunEnd
  } blit_phase_e;

  cfg_t        shadow_cfg;
  blit_phase_e blit_phase;
  logic [21:0] rom_ptr;
  logic [7:0]  cur_x, cur_y, row_x, run_left, flags;
  logic [3:0]  run_pen;
  out_item_t   expected_beats[$];
  out_item_t   want;
  int          mismatches;

  // one bit per layer and half, layers taken from the low nibble
  function automatic logic [7:0] layer_halves(input logic other_half_too);
    logic [7:0] m;
    m = '0;
    for (int l = 0; l < 4; l++) begin
      if (shadow_cfg.dest_layers[l]) begin
        m[2*l + (shadow_cfg.active_half ? 1 : 0)] = 1'b1;
        if (other_half_too) begin
          m[2*l + (shadow_cfg.active_half ? 0 : 1)] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  function automatic logic [7:0] planes_for(input logic fill);
    case (shadow_cfg.layout_mode)
      LayoutFour:      return layer_halves(fill);
      LayoutFourDual:  return layer_halves(shadow_cfg.both_halves);
      LayoutThreePair: return {2'b00, shadow_cfg.dest_layers[5:0]};
      default: return {5'b0, shadow_cfg.dest_layers[1], 1'b0, shadow_cfg.dest_layers[0]};
    endcase
  endfunction

  // fetch request, or done with overrun once the pointer leaves the rom
  task automatic issue_fetch(input blit_phase_e next_phase);
    out_item_t r;
    r = '0;
    r.address = rom_ptr;
    if ({1'b0, rom_ptr} >= shadow_cfg.rom_length) begin
      r.kind    = KindDone;
      r.overrun = 1'b1;
      r.irq     = shadow_cfg.irq_enable;
      blit_phase = BlitIdle;
    end else begin
      r.kind     = KindFetch;
      blit_phase = next_phase;
    end
    expected_beats.push_back(r);
  endtask

  task automatic predict_blit_step(input in_item_t beat);
    out_item_t  r;
    logic [7:0] b, x, y, t, pen;
    r = '0;
    b = beat.rom_byte;
    case (beat.func)
      FuncStart: begin
        flags    = beat.blit_flags;
        rom_ptr  = beat.src_address & SrcAddrMask;
        cur_x    = beat.dest_xy[7:0];
        cur_y    = beat.dest_xy[15:8];
        row_x    = beat.dest_xy[7:0];
        run_left = '0;
        run_pen  = '0;
        if (flags[FlagFill]) begin
          r.kind        = KindFill;
          r.address     = shadow_cfg.flip_screen ? 22'd0 : {6'd0, beat.dest_xy};
          r.pen         = {4'd0, shadow_cfg.pen_register[7:4]};
          r.plane_mask  = planes_for(1'b1);
          r.fill_length = 17'h10000 - {1'b0, beat.dest_xy};
          blit_phase    = BlitIdle;
          expected_beats.push_back(r);
        end else begin
          issue_fetch(BlitCmd);
        end
      end
      FuncDeliver: begin
        case (blit_phase)
          BlitCmd: begin
            rom_ptr = (rom_ptr + 22'd1) & SrcAddrMask;
            run_pen = b[7:4];
            if (b[3:0] == OpStop) begin
              r.kind     = KindDone;
              r.address  = rom_ptr;
              r.irq      = shadow_cfg.irq_enable;
              blit_phase = BlitIdle;
              expected_beats.push_back(r);
            end else if (b[3:0] == OpNextRow) begin
              cur_y = flags[FlagSwap] ? cur_y - 8'd1 : cur_y + 8'd1;
              cur_x = row_x;
              issue_fetch(BlitCmd);
            end else if (b[3:0] == OpSkipA || b[3:0] == OpSkipB) begin
              issue_fetch(BlitSkip);
            end else if (b[3:0] == OpCount) begin
              issue_fetch(BlitCount);
            end else begin
              run_left   = {4'd0, b[3:0]};
              blit_phase = BlitDraw;
            end
          end
          BlitSkip: begin
            rom_ptr = (rom_ptr + 22'd1) & SrcAddrMask;
            cur_x   = row_x + b;
            issue_fetch(BlitCount);
          end
          BlitCount: begin
            rom_ptr = (rom_ptr + 22'd1) & SrcAddrMask;
            if (b == 8'd0) begin
              issue_fetch(BlitCmd);
            end else begin
              run_left   = b;
              blit_phase = BlitDraw;
            end
          end
          default: ;
        endcase
      end
      FuncAdvance: begin
        if (blit_phase == BlitDraw) begin
          x = cur_x;
          y = cur_y;
          if (shadow_cfg.flip_screen) begin
            x = ~x;
            y = ~y;
          end
          if (flags[FlagSwap]) begin
            t = x;
            x = y;
            y = t;
          end
          pen = {4'd0, run_pen};
          if (flags[FlagOverride]) pen = {4'd0, shadow_cfg.pen_register[7:4]};
          if (shadow_cfg.dest_layers[LayerPenOr]) begin
            pen = pen | {shadow_cfg.pen_register[6:0], 1'b0};
          end
          r.kind       = KindPixel;
          r.address    = {6'd0, y, x};
          r.pen        = pen;
          r.plane_mask = planes_for(1'b0);
          expected_beats.push_back(r);
          cur_x    = cur_x + 8'd1;
          run_left = run_left - 8'd1;
          if (run_left == 8'd0) blit_phase = BlitRunEnd;
        end else if (blit_phase == BlitRunEnd) begin
          issue_fetch(BlitCmd);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_result(input bit orphan, input out_item_t exp_beat,
                               input out_item_t act_beat);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan) begin
        $display("unexpected result beat: kind=%0d addr=%h pen=%h mask=%h len=%h ovr=%b irq=%b",
                 act_beat.kind, act_beat.address, act_beat.pen, act_beat.plane_mask,
                 act_beat.fill_length, act_beat.overrun, act_beat.irq);
      end else begin
        $display("result mismatch: exp kind=%0d addr=%h pen=%h mask=%h len=%h ovr=%b irq=%b",
                 exp_beat.kind, exp_beat.address, exp_beat.pen, exp_beat.plane_mask,
                 exp_beat.fill_length, exp_beat.overrun, exp_beat.irq);
        $display("                 got kind=%0d addr=%h pen=%h mask=%h len=%h ovr=%b irq=%b",
                 act_beat.kind, act_beat.address, act_beat.pen, act_beat.plane_mask,
                 act_beat.fill_length, act_beat.overrun, act_beat.irq);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_cfg            = '0;
      shadow_cfg.irq_enable = 1'b1;
      shadow_cfg.rom_length = 23'd4194304;
      blit_phase = BlitIdle;
      rom_ptr    = '0;
      cur_x      = '0;
      cur_y      = '0;
      row_x      = '0;
      run_left   = '0;
      run_pen    = '0;
      flags      = '0;
      mismatches = 0;
      expected_beats.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          report_result(1'b1, '0, out_data_i);
        end else begin
          want = expected_beats.pop_front();
          if (out_data_i.kind !== want.kind || out_data_i.address !== want.address ||
              out_data_i.pen !== want.pen || out_data_i.plane_mask !== want.plane_mask ||
              out_data_i.fill_length !== want.fill_length ||
              out_data_i.overrun !== want.overrun || out_data_i.irq !== want.irq) begin
            report_result(1'b0, want, out_data_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegLayoutMode:  shadow_cfg.layout_mode  = cfg_data_i[1:0];
          RegDestLayers:  shadow_cfg.dest_layers  = cfg_data_i[7:0];
          RegPenRegister: shadow_cfg.pen_register = cfg_data_i[7:0];
          RegActiveHalf:  shadow_cfg.active_half  = cfg_data_i[0];
          RegBothHalves:  shadow_cfg.both_halves  = cfg_data_i[0];
          RegFlipScreen:  shadow_cfg.flip_screen  = cfg_data_i[0];
          RegIrqEnable:   shadow_cfg.irq_enable   = cfg_data_i[0];
          RegRomLength:   shadow_cfg.rom_length   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_blit_step(in_data_i);
      end
      mismatches_o  <= mismatches;
      outstanding_o <= expected_beats.size();
    end
  end

endmodule

### dv/rle_blitter_command_engine_core_tb.sv
// ----------------------------------------------------------------------------
// rle_blitter_command_engine_core_tb: testbench for the blitter command engine
// feeds start, rom byte and advance beats shaped as real command streams,
// rewrites the configuration between phases and lets the checker compare
// every result beat against its own prediction
// ----------------------------------------------------------------------------
module rle_blitter_command_engine_core_tb;
  import rbce_pkg::*;

  localparam int CycleLimit  = 600000;
  localparam int QuietCycles = 8;
  localparam int PhaseCount  = 8;
  localparam int PhaseBeats  = 150;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_beat   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_beat;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = RegLayoutMode;
  logic [22:0] cfg_data  = '0;

  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;
  int   sent        = 0;
  int   burst_left  = 1;
  cfg_t run_cfg;

  // receiver stall pattern state
  int   stall_mode = 0;
  int   stall_left = 0;
  int   stall_tick = 0;

  always #6 clk = ~clk;

  rle_blitter_command_engine_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  rle_blitter_command_engine_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_beat),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_beat),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("rle_blitter_command_engine_core_tb: FAIL");
      $finish;
    end
  end

  // receiver stall: switches at random between free flow, random, periodic
  // and heavy back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      stall_tick <= stall_tick + 1;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        2:       out_stall <= ((stall_tick % 5) < 2);
        default: out_stall <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // beat builders; fields a beat does not use carry random bits
  function automatic in_item_t start_beat(input logic [21:0] src, input logic [15:0] dest,
                                          input logic [7:0] flags);
    in_item_t b;
    b.func        = FuncStart;
    b.src_address = src;
    b.dest_xy     = dest;
    b.blit_flags  = flags;
    b.rom_byte    = 8'($urandom);
    return b;
  endfunction

  function automatic in_item_t byte_beat(input logic [7:0] rom_byte);
    in_item_t b;
    b.func        = FuncDeliver;
    b.src_address = 22'($urandom);
    b.dest_xy     = 16'($urandom);
    b.blit_flags  = 8'($urandom);
    b.rom_byte    = rom_byte;
    return b;
  endfunction

  function automatic in_item_t advance_beat();
    in_item_t b;
    b = byte_beat(8'($urandom));
    b.func = FuncAdvance;
    return b;
  endfunction

  // one input beat; bursts of random length separated by random gaps
  task automatic send_beat(input in_item_t b);
    int gap;
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off the sender until every predicted result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [22:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all eight registers back to back, valid held high across them
  task automatic load_config(input cfg_t c);
    run_cfg = c;
    cfg_valid <= 1'b1;
    put_reg(RegLayoutMode,  23'(c.layout_mode));
    put_reg(RegDestLayers,  23'(c.dest_layers));
    put_reg(RegPenRegister, 23'(c.pen_register));
    put_reg(RegActiveHalf,  23'(c.active_half));
    put_reg(RegBothHalves,  23'(c.both_halves));
    put_reg(RegFlipScreen,  23'(c.flip_screen));
    put_reg(RegIrqEnable,   23'(c.irq_enable));
    put_reg(RegRomLength,   c.rom_length);
    cfg_valid <= 1'b0;
  endtask

  // source address: often just below the rom end or the pointer wrap
  function automatic logic [21:0] pick_src();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      if (run_cfg.rom_length > 23'd24) return 22'(run_cfg.rom_length - $urandom_range(0, 24));
      return 22'($urandom_range(0, 30));
    end
    if (r < 40) return 22'h3fffff - 22'($urandom_range(0, 8));
    return 22'($urandom);
  endfunction

  // count byte, then the pixels of the run and the advance that ends it
  task automatic counted_run();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 6) n = 0;
    else if (r < 9) n = $urandom_range(100, 255);
    else n = $urandom_range(1, 8);
    send_beat(byte_beat(8'(n)));
    if (n != 0) begin
      repeat (n + 1) send_beat(advance_beat());
    end
  endtask

  // one well-formed blit with random content, sometimes abandoned
  task automatic run_blit();
    int         r, n_cmds, len;
    logic [7:0] flags;
    logic [15:0] dest;
    logic [3:0] pen;
    flags           = 8'($urandom);
    flags[FlagFill] = ($urandom_range(0, 99) < 15);
    case ($urandom_range(0, 19))
      0:       dest = 16'h0000;
      1:       dest = 16'hffff;
      2:       dest = 16'h00ff;
      3:       dest = 16'hff00;
      default: dest = 16'($urandom);
    endcase
    send_beat(start_beat(pick_src(), dest, flags));
    if (flags[FlagFill]) return;
    n_cmds = $urandom_range(1, 10);
    repeat (n_cmds) begin
      // walking away mid-blit leaves the next start to abort it
      if ($urandom_range(0, 99) < 3) return;
      pen = 4'($urandom);
      r   = $urandom_range(0, 99);
      if (r < 45) begin
        len = $urandom_range(1, 11);
        send_beat(byte_beat({pen, 4'(len)}));
        repeat (len + 1) send_beat(advance_beat());
      end else if (r < 60) begin
        send_beat(byte_beat({pen, OpCount}));
        counted_run();
      end else if (r < 75) begin
        send_beat(byte_beat({pen, ($urandom_range(0, 1) != 0) ? OpSkipA : OpSkipB}));
        send_beat(byte_beat(8'($urandom)));
        counted_run();
      end else begin
        send_beat(byte_beat({pen, OpNextRow}));
      end
    end
    if ($urandom_range(0, 99) < 85) send_beat(byte_beat({4'($urandom), OpStop}));
  endtask

  task automatic noise_beat();
    in_item_t b;
    b.func        = 2'($urandom);
    b.src_address = 22'($urandom);
    b.dest_xy     = 16'($urandom);
    b.blit_flags  = 8'($urandom);
    b.rom_byte    = 8'($urandom);
    send_beat(b);
  endtask

  task automatic directed_beats();
    // fills at both ends of the frame buffer: full length and one byte
    send_beat(start_beat(22'd0, 16'h0000, 8'h01));
    send_beat(start_beat(22'h3fffff, 16'hffff, 8'hff));
    // short run crossing the x wrap, then next row with pointer wrap
    send_beat(start_beat(22'h3ffffe, 16'h00fe, 8'h00));
    send_beat(byte_beat(8'hf3));
    repeat (4) send_beat(advance_beat());
    send_beat(byte_beat(8'h0f));
    // counted run with a zero count, then a skip with the widest offset
    send_beat(byte_beat({4'h5, OpCount}));
    send_beat(byte_beat(8'h00));
    send_beat(byte_beat({4'h7, OpSkipA}));
    send_beat(byte_beat(8'hff));
    send_beat(byte_beat(8'h02));
    repeat (3) send_beat(advance_beat());
    send_beat(byte_beat({4'h8, OpSkipB}));
    send_beat(byte_beat(8'h10));
    send_beat(byte_beat(8'h00));
    // misplaced advance is ignored, then a noise beat with a random func code
    send_beat(advance_beat());
    noise_beat();
    send_beat(byte_beat({4'ha, OpStop}));
    // swapped and upward with pen override, aborted by a restart mid-run
    send_beat(start_beat(22'h155555, 16'h80c0, 8'h0a));
    send_beat(byte_beat({4'h4, OpNextRow}));
    send_beat(byte_beat(8'h6b));
    send_beat(advance_beat());
    send_beat(start_beat(22'h2aaaaa, 16'h7f3f, 8'h00));
    send_beat(byte_beat({4'hb, OpStop}));
  endtask

  initial begin
    cfg_t c;
    int   phase_start, r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    c              = '0;
    c.layout_mode  = LayoutFourDual;
    c.dest_layers  = 8'h1f;
    c.pen_register = 8'ha5;
    c.active_half  = 1'b1;
    c.irq_enable   = 1'b1;
    c.rom_length   = 23'd4194304;
    load_config(c);
    directed_beats();

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      if (p == 0) begin
        c             = '0;
        c.dest_layers = 8'h0f;
        c.irq_enable  = 1'b1;
        c.rom_length  = 23'd4194304;
      end else if (p == 1) begin
        c.layout_mode  = LayoutFourDual;
        c.dest_layers  = 8'hff;
        c.pen_register = 8'hff;
        c.active_half  = 1'b1;
        c.both_halves  = 1'b1;
        c.flip_screen  = 1'b1;
        c.irq_enable   = 1'b0;
        c.rom_length   = 23'd0;
      end else begin
        c.layout_mode  = 2'(p);
        c.dest_layers  = 8'($urandom);
        c.pen_register = 8'($urandom);
        c.active_half  = 1'($urandom);
        c.both_halves  = 1'($urandom);
        c.flip_screen  = 1'($urandom);
        c.irq_enable   = 1'($urandom);
        case ($urandom_range(0, 3))
          0:       c.rom_length = 23'd4194304;
          1:       c.rom_length = 23'd4194303;
          2:       c.rom_length = 23'($urandom_range(0, 4194304));
          default: c.rom_length = 23'($urandom_range(1, 64));
        endcase
      end
      load_config(c);
      phase_start = sent;
      while (sent - phase_start < PhaseBeats) begin
        r = $urandom_range(0, 99);
        if (r < 8) noise_beat();
        else if (r < 9) drain_results();
        else run_blit();
      end
    end

    drain_results();
    if (mismatches == 0 && outstanding == 0) begin
      $display("rle_blitter_command_engine_core_tb: PASS");
    end else begin
      $display("rle_blitter_command_engine_core_tb: FAIL");
    end
    $finish;
  end

endmodule
